// ===== rtl/sparse_sample_speed_estimator_defines.svh =====
// assertion helpers for the rtl, used by sse_ctrl
`ifndef SPARSE_SAMPLE_SPEED_ESTIMATOR_DEFINES_SVH
`define SPARSE_SAMPLE_SPEED_ESTIMATOR_DEFINES_SVH

// same-cycle implication
`define SSE_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define SSE_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/sse_pkg.sv =====
package sse_pkg;

  localparam int POS_W     = 24;
  localparam int TIME_W    = 32;
  localparam int SPD_W     = 24;
  localparam int EPS_W     = 10;
  localparam int LIM_W     = 23;
  localparam int TMO_W     = 16;
  localparam int RC_W      = 20;
  localparam int MAG_W     = POS_W + 1;
  localparam int K_W       = 10;
  localparam int NPROD_W   = MAG_W + K_W;
  localparam int DT_W      = TIME_W + K_W;
  localparam int DEN_W     = DT_W + 1;
  localparam int REM_W     = DEN_W + 1;
  localparam int QUO_W     = LIM_W;
  localparam int ALPHA_W   = 17;
  localparam int FRAC_W    = 16;
  localparam int SPROD_W   = MAG_W + ALPHA_W;
  localparam int SMAG_W    = SPROD_W - FRAC_W;
  localparam int CNT_W     = 5;
  localparam int SPD_BITS  = QUO_W;
  localparam int ALP_BITS  = ALPHA_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [K_W-1:0]    MS_TO_US = K_W'(1000);
  localparam logic [SPROD_W-1:0] HALF_LSB = SPROD_W'(32768);

  localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(51);
  localparam logic [LIM_W-1:0] LIM_RST = LIM_W'(1024000);
  localparam logic [TMO_W-1:0] TMO_RST = TMO_W'(250);
  localparam logic [RC_W-1:0]  RC_RST  = RC_W'(53052);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EPSILON = 3'd0,
    CFG_LIMIT   = 3'd1,
    CFG_TIMEOUT = 3'd2,
    CFG_RC      = 3'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_PRIME = 3'd2,
    OP_TAKE  = 3'd3,
    OP_STILL = 3'd4
  } op_t;

  typedef struct packed {
    logic load;
    logic eval;
    op_t  op;
    logic spd_load;
    logic alp_load;
    logic div_step;
    logic diff_load;
    logic mul;
    logic upd;
    logic out_load;
  } sse_cmd_t;

  typedef struct packed {
    logic restart;
    logic primed;
    logic moved;
    logic elapsed_zero;
    logic sat;
  } sse_sts_t;

endpackage

// ===== rtl/sse_div.sv =====
module sse_div (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [sse_pkg::REM_W-1:0] load_rem,
  input  logic [sse_pkg::QUO_W-1:0] load_quo,
  input  logic [sse_pkg::DEN_W-1:0] load_den,
  output logic [sse_pkg::QUO_W-1:0] quo
);
  import sse_pkg::*;

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [REM_W-1:0] trial_c;
  logic             ge_c;

  // restoring division, one quotient bit per step, numerator bits shift out of quo
  assign trial_c = {rem_r[REM_W-2:0], quo_r[QUO_W-1]};
  assign ge_c    = trial_c >= REM_W'(den_r);

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    if (load) begin
      rem_nxt = load_rem;
      quo_nxt = load_quo;
      den_nxt = load_den;
    end else if (step) begin
      rem_nxt = ge_c ? trial_c - REM_W'(den_r) : trial_c;
      quo_nxt = {quo_r[QUO_W-2:0], ge_c};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quo = quo_r;

endmodule

// ===== rtl/sse_dp.sv =====
module sse_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sse_pkg::sse_cmd_t             cmd,
  output sse_pkg::sse_sts_t             sts,
  input  logic signed [sse_pkg::POS_W-1:0] in_position,
  input  logic [sse_pkg::TIME_W-1:0]    in_now_ms,
  input  logic                          in_restart,
  input  logic [sse_pkg::EPS_W-1:0]     motion_epsilon,
  input  logic [sse_pkg::LIM_W-1:0]     raw_speed_limit,
  input  logic [sse_pkg::TMO_W-1:0]     still_timeout_ms,
  input  logic [sse_pkg::RC_W-1:0]      filter_rc_us,
  output logic signed [sse_pkg::SPD_W-1:0] out_speed,
  output logic                          out_new_sample
);
  import sse_pkg::*;

  // item capture
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              restart_r, restart_nxt;

  // estimator state
  logic              primed_r, primed_nxt;
  logic [POS_W-1:0]  ref_pos_r, ref_pos_nxt;
  logic [TIME_W-1:0] ref_time_r, ref_time_nxt;
  logic [TIME_W-1:0] last_time_r, last_time_nxt;
  logic [SPD_W-1:0]  filt_r, filt_nxt;
  logic              fresh_r, fresh_nxt;

  // per-item working values
  logic               neg_r, neg_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic [NPROD_W-1:0] prod_n_r, prod_n_nxt;
  logic [DT_W-1:0]    prod_dt_r, prod_dt_nxt;
  logic               sat_r, sat_nxt;
  logic [LIM_W-1:0]   rmag_r, rmag_nxt;
  logic               dneg_r, dneg_nxt;
  logic [MAG_W-1:0]   dmag_r, dmag_nxt;
  logic [SPROD_W-1:0] prod_s_r, prod_s_nxt;
  logic [SPD_W-1:0]   out_speed_r, out_speed_nxt;
  logic               out_new_r, out_new_nxt;

  logic [MAG_W-1:0]   delta_c, mag_c;
  logic               neg_c;
  logic [TIME_W-1:0]  elapsed_c;
  logic               still_c;
  logic               sat_c;
  logic [QUO_W-1:0]   quo_c;
  logic               div_load_c;
  logic [REM_W-1:0]   div_rem_c;
  logic [QUO_W-1:0]   div_quo_c;
  logic [DEN_W-1:0]   div_den_c;
  logic [MAG_W-1:0]   raw_c, diff_c;
  logic [SMAG_W-1:0]  smag_c;
  logic [SPROD_W-1:0] round_c;
  logic [SMAG_W-1:0]  fext_c, sum_c;

  assign delta_c   = {pos_r[POS_W-1], pos_r} - {ref_pos_r[POS_W-1], ref_pos_r};
  assign neg_c     = delta_c[MAG_W-1];
  assign mag_c     = neg_c ? (~delta_c + MAG_W'(1)) : delta_c;
  assign elapsed_c = now_r - ref_time_r;
  assign still_c   = (now_r - last_time_r) >= TIME_W'(still_timeout_ms);

  // quotient of 2^23 or more is clamped anyway
  assign sat_c = (prod_n_r >> SPD_BITS) >= NPROD_W'(elapsed_r);

  assign sts.restart      = restart_r;
  assign sts.primed       = primed_r;
  assign sts.moved        = mag_c >= MAG_W'(motion_epsilon);
  assign sts.elapsed_zero = (elapsed_c == '0);
  assign sts.sat          = sat_c;

  // shared divider: speed = mag*1000/elapsed, then alpha = dt*65536/(rc+dt)
  assign div_load_c = cmd.spd_load | cmd.alp_load;
  always_comb begin
    if (cmd.alp_load) begin
      div_rem_c = REM_W'(prod_dt_r >> 1);
      div_quo_c = {prod_dt_r[0], (QUO_W-1)'(0)};
      div_den_c = DEN_W'(filter_rc_us) + DEN_W'(prod_dt_r);
    end else begin
      div_rem_c = REM_W'(prod_n_r >> SPD_BITS);
      div_quo_c = prod_n_r[QUO_W-1:0];
      div_den_c = DEN_W'(elapsed_r);
    end
  end

  sse_div u_div (
    .clk      (clk),
    .load     (div_load_c),
    .step     (cmd.div_step),
    .load_rem (div_rem_c),
    .load_quo (div_quo_c),
    .load_den (div_den_c),
    .quo      (quo_c)
  );

  assign raw_c   = neg_r ? (~MAG_W'(rmag_r) + MAG_W'(1)) : MAG_W'(rmag_r);
  assign diff_c  = raw_c - {filt_r[SPD_W-1], filt_r};
  assign round_c = prod_s_r + HALF_LSB;
  assign smag_c  = round_c[SPROD_W-1:FRAC_W];
  assign fext_c  = SMAG_W'($signed(filt_r));
  assign sum_c   = dneg_r ? fext_c - smag_c : fext_c + smag_c;

  always_comb begin
    pos_nxt       = pos_r;
    now_nxt       = now_r;
    restart_nxt   = restart_r;
    primed_nxt    = primed_r;
    ref_pos_nxt   = ref_pos_r;
    ref_time_nxt  = ref_time_r;
    last_time_nxt = last_time_r;
    filt_nxt      = filt_r;
    fresh_nxt     = fresh_r;
    neg_nxt       = neg_r;
    elapsed_nxt   = elapsed_r;
    prod_n_nxt    = prod_n_r;
    prod_dt_nxt   = prod_dt_r;
    sat_nxt       = sat_r;
    rmag_nxt      = rmag_r;
    dneg_nxt      = dneg_r;
    dmag_nxt      = dmag_r;
    prod_s_nxt    = prod_s_r;
    out_speed_nxt = out_speed_r;
    out_new_nxt   = out_new_r;

    if (cmd.load) begin
      pos_nxt     = in_position;
      now_nxt     = in_now_ms;
      restart_nxt = in_restart;
    end

    if (cmd.eval) begin
      neg_nxt     = neg_c;
      elapsed_nxt = elapsed_c;
      prod_n_nxt  = NPROD_W'(mag_c) * NPROD_W'(MS_TO_US);
      prod_dt_nxt = DT_W'(elapsed_c) * DT_W'(MS_TO_US);
      fresh_nxt   = 1'b0;
      unique case (cmd.op)
        OP_CLEAR: begin
          primed_nxt = 1'b0;
          filt_nxt   = '0;
        end
        OP_PRIME: begin
          primed_nxt    = 1'b1;
          ref_pos_nxt   = pos_r;
          ref_time_nxt  = now_r;
          last_time_nxt = now_r;
          filt_nxt      = '0;
        end
        OP_TAKE: begin
          ref_pos_nxt   = pos_r;
          ref_time_nxt  = now_r;
          last_time_nxt = now_r;
          fresh_nxt     = 1'b1;
        end
        OP_STILL: begin
          if (still_c) begin
            filt_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.spd_load) begin
      sat_nxt = sat_c;
    end

    if (cmd.alp_load) begin
      rmag_nxt = (sat_r || quo_c > raw_speed_limit) ? raw_speed_limit : quo_c;
    end

    if (cmd.diff_load) begin
      dneg_nxt = diff_c[MAG_W-1];
      dmag_nxt = diff_c[MAG_W-1] ? (~diff_c + MAG_W'(1)) : diff_c;
    end

    if (cmd.mul) begin
      prod_s_nxt = SPROD_W'(dmag_r) * SPROD_W'(quo_c[ALPHA_W-1:0]);
    end

    if (cmd.upd) begin
      filt_nxt = sum_c[SPD_W-1:0];
    end

    if (cmd.out_load) begin
      out_speed_nxt = filt_r;
      out_new_nxt   = fresh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= 1'b0;
      ref_pos_r   <= '0;
      ref_time_r  <= '0;
      last_time_r <= '0;
      filt_r      <= '0;
      fresh_r     <= 1'b0;
    end else begin
      primed_r    <= primed_nxt;
      ref_pos_r   <= ref_pos_nxt;
      ref_time_r  <= ref_time_nxt;
      last_time_r <= last_time_nxt;
      filt_r      <= filt_nxt;
      fresh_r     <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    now_r       <= now_nxt;
    restart_r   <= restart_nxt;
    neg_r       <= neg_nxt;
    elapsed_r   <= elapsed_nxt;
    prod_n_r    <= prod_n_nxt;
    prod_dt_r   <= prod_dt_nxt;
    sat_r       <= sat_nxt;
    rmag_r      <= rmag_nxt;
    dneg_r      <= dneg_nxt;
    dmag_r      <= dmag_nxt;
    prod_s_r    <= prod_s_nxt;
    out_speed_r <= out_speed_nxt;
    out_new_r   <= out_new_nxt;
  end

  assign out_speed      = out_speed_r;
  assign out_new_sample = out_new_r;

endmodule

// ===== rtl/sse_ctrl.sv =====
`include "sparse_sample_speed_estimator_defines.svh"

module sse_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  sse_pkg::sse_sts_t  sts,
  output sse_pkg::sse_cmd_t  cmd
);
  import sse_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EVAL  = 9'b000000010,
    S_SPDLD = 9'b000000100,
    S_DIVS  = 9'b000001000,
    S_ALPLD = 9'b000010000,
    S_DIVA  = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_UPD   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire_c;
  logic             out_free_c;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire_c  = in_tvalid & in_tready;
  assign out_free_c = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire_c) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        priority if (sts.restart) begin
          cmd.op    = OP_CLEAR;
          state_nxt = S_FIN;
        end else if (!sts.primed) begin
          cmd.op    = OP_PRIME;
          state_nxt = S_FIN;
        end else if (!sts.moved) begin
          cmd.op    = OP_STILL;
          state_nxt = S_FIN;
        end else if (sts.elapsed_zero) begin
          cmd.op    = OP_TAKE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_TAKE;
          state_nxt = S_SPDLD;
        end
      end
      S_SPDLD: begin
        cmd.spd_load = 1'b1;
        cnt_nxt      = CNT_W'(SPD_BITS - 1);
        state_nxt    = sts.sat ? S_ALPLD : S_DIVS;
      end
      S_DIVS: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_ALPLD;
        end
      end
      S_ALPLD: begin
        cmd.alp_load = 1'b1;
        cnt_nxt      = CNT_W'(ALP_BITS - 1);
        state_nxt    = S_DIVA;
      end
      S_DIVA: begin
        cmd.div_step  = 1'b1;
        cmd.diff_load = 1'b1;
        cnt_nxt       = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free_c) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SSE_ASSERT_NXT(a_fire_eval, in_fire_c, state_r == S_EVAL, "accepted item not evaluated")
  `SSE_ASSERT_NXT(a_divs_done, (state_r == S_DIVS) && (cnt_r == '0), state_r == S_ALPLD, "speed divide overran")
  `SSE_ASSERT_NOW(a_fin_load, (state_r == S_FIN) && !out_free_c, !cmd.out_load, "result overwrote pending item")
  `SSE_ASSERT_NXT(a_fin_idle, (state_r == S_FIN) && out_free_c, out_tvalid && (state_r == S_IDLE), "result not issued")

endmodule

// ===== rtl/sparse_sample_speed_estimator.sv =====
// a restart, priming, no-motion or zero-elapsed item goes from accept through EVAL and FIN
// to the result; a differentiated sample also passes SPDLD, DIVS, ALPLD, DIVA, MUL and UPD
// (DIVS is skipped when the raw speed saturates); FIN waits while the output is stalled
// one item at a time: no new item is accepted until its result is loaded; the shared
// bit-serial divider takes 23 steps for speed and 17 steps for the filter coefficient
// reset: rst_n synchronous active low; clears the estimator and loads register defaults
module sparse_sample_speed_estimator (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sse_pkg::CFG_DAT_W-1:0]   cfg_data,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [55:0]                     in_tdata,  // position[23:0], now_ms[55:24]
  input  logic                            in_tuser,  // restart[0]
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata, // speed[23:0]
  output logic                            out_tuser  // new_sample[0]
);
  import sse_pkg::*;

  logic [EPS_W-1:0] eps_r, eps_nxt;
  logic [LIM_W-1:0] lim_r, lim_nxt;
  logic [TMO_W-1:0] tmo_r, tmo_nxt;
  logic [RC_W-1:0]  rc_r, rc_nxt;
  logic             cfg_fire_c;

  sse_cmd_t         cmd;
  sse_sts_t         sts;
  logic [SPD_W-1:0] speed_c;
  logic             new_sample_c;

  assign cfg_ready  = 1'b1;
  assign cfg_fire_c = cfg_valid & cfg_ready;

  always_comb begin
    eps_nxt = eps_r;
    lim_nxt = lim_r;
    tmo_nxt = tmo_r;
    rc_nxt  = rc_r;
    if (cfg_fire_c) begin
      unique case (cfg_index)
        CFG_EPSILON: eps_nxt = cfg_data[EPS_W-1:0];
        CFG_LIMIT:   lim_nxt = cfg_data[LIM_W-1:0];
        CFG_TIMEOUT: tmo_nxt = cfg_data[TMO_W-1:0];
        CFG_RC:      rc_nxt  = cfg_data[RC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RST;
      lim_r <= LIM_RST;
      tmo_r <= TMO_RST;
      rc_r  <= RC_RST;
    end else begin
      eps_r <= eps_nxt;
      lim_r <= lim_nxt;
      tmo_r <= tmo_nxt;
      rc_r  <= rc_nxt;
    end
  end

  sse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sse_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_position      (in_tdata[POS_W-1:0]),
    .in_now_ms        (in_tdata[POS_W+TIME_W-1:POS_W]),
    .in_restart       (in_tuser),
    .motion_epsilon   (eps_r),
    .raw_speed_limit  (lim_r),
    .still_timeout_ms (tmo_r),
    .filter_rc_us     (rc_r),
    .out_speed        (speed_c),
    .out_new_sample   (new_sample_c)
  );

  assign out_tdata = speed_c;
  assign out_tuser = new_sample_c;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import sse_pkg::*;

  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 195;
  localparam int CALM_ITEMS = 150;
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_IDX = CFG_IDX_W'(CFG_RC) + 1'b1;

  typedef struct packed {
    logic [SPD_W-1:0] speed;
    logic             new_sample;
  } speed_item_t;

  typedef struct {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    logic [POS_W-1:0]     pos;
    logic [TIME_W-1:0]    now;
    logic                 restart;
    logic                 typed;
    speed_item_t          want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [55:0]          in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic                 out_tuser;

  sparse_sample_speed_estimator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // estimator copy: registers and state
  logic [EPS_W-1:0]        est_eps;
  logic [LIM_W-1:0]        est_limit;
  logic [TMO_W-1:0]        est_timeout;
  logic [RC_W-1:0]         est_rc;
  logic                    est_primed;
  logic signed [POS_W-1:0] est_ref_pos;
  logic [TIME_W-1:0]       est_ref_time;
  logic [TIME_W-1:0]       est_motion_time;
  logic signed [SPD_W-1:0] est_speed;

  speed_item_t pending_speeds[$];
  int          mismatches = 0;
  bit          calm = 1'b0;
  int          ready_hold = 0;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void load_speed_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_EPSILON: est_eps = data[EPS_W-1:0];
      CFG_LIMIT:   est_limit = data[LIM_W-1:0];
      CFG_TIMEOUT: est_timeout = data[TMO_W-1:0];
      CFG_RC:      est_rc = data[RC_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic speed_item_t estimate_speed(logic signed [POS_W-1:0] pos,
                                                 logic [TIME_W-1:0] now, logic restart);
    speed_item_t        res;
    longint             delta, raw, diff, stp;
    longint unsigned    mag, rmag, dt_us, alpha, dmag, smag;
    logic [TIME_W-1:0]  elapsed, still_ms;
    res.new_sample = 1'b0;
    if (restart) begin
      est_primed = 1'b0;
      est_speed = '0;
    end else if (!est_primed) begin
      est_ref_pos = pos;
      est_ref_time = now;
      est_motion_time = now;
      est_primed = 1'b1;
      est_speed = '0;
    end else begin
      delta = longint'(pos) - longint'(est_ref_pos);
      mag = (delta < 0) ? -delta : delta;
      if (mag >= est_eps) begin
        elapsed = now - est_ref_time;
        res.new_sample = 1'b1;
        if (elapsed != 0) begin
          rmag = (mag * 1000) / elapsed;
          dt_us = 64'(elapsed);
          dt_us = dt_us * 1000;
          alpha = (dt_us * 65536) / (est_rc + dt_us);
          if (rmag > est_limit) rmag = 64'(est_limit);
          raw = (delta < 0) ? -longint'(rmag) : longint'(rmag);
          diff = raw - longint'(est_speed);
          dmag = (diff < 0) ? -diff : diff;
          // rounded half away from zero on the magnitude
          smag = (dmag * alpha + 32768) >> FRAC_W;
          stp = (diff < 0) ? -longint'(smag) : longint'(smag);
          est_speed = SPD_W'(longint'(est_speed) + stp);
        end
        est_ref_pos = pos;
        est_ref_time = now;
        est_motion_time = now;
      end else begin
        still_ms = now - est_motion_time;
        if (still_ms >= est_timeout) est_speed = '0;
      end
    end
    res.speed = est_speed;
    return res;
  endfunction

  function automatic plan_row_t item_row(logic [POS_W-1:0] pos, logic [TIME_W-1:0] now,
                                         logic restart);
    plan_row_t row;
    row = '{default: '0};
    row.pos = pos;
    row.now = now;
    row.restart = restart;
    return row;
  endfunction

  function automatic plan_row_t known_row(logic [POS_W-1:0] pos, logic [TIME_W-1:0] now,
                                          logic restart, logic [SPD_W-1:0] speed,
                                          logic new_sample);
    plan_row_t row;
    row = item_row(pos, now, restart);
    row.typed = 1'b1;
    row.want.speed = speed;
    row.want.new_sample = new_sample;
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  // registers only change once every result is back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    in_tvalid <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    load_speed_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_item(logic [POS_W-1:0] pos, logic [TIME_W-1:0] now, logic restart,
                           logic typed, speed_item_t want);
    int          gap;
    speed_item_t got;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {now, pos};
    in_tuser <= restart;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    got = estimate_speed(pos, now, restart);
    pending_speeds.push_back(typed ? want : got);
  endtask

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    speed_item_t exp_item;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_speeds.size() == 0) begin
        report_mismatch($sformatf("unexpected item speed %h new %b", out_tdata, out_tuser));
      end else begin
        exp_item = pending_speeds.pop_front();
        if (out_tdata !== exp_item.speed)
          report_mismatch($sformatf("speed %h, expected %h", out_tdata, exp_item.speed));
        if (out_tuser !== exp_item.new_sample)
          report_mismatch($sformatf("new_sample %b, expected %b", out_tuser,
                                    exp_item.new_sample));
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    plan_row_t            plan[$];
    speed_item_t          none;
    int                   ph, k, r, mag;
    logic [TIME_W-1:0]    gen_now, dt;
    logic [POS_W-1:0]     gen_pos, pos;
    logic                 restart;
    logic [EPS_W-1:0]     v_eps;
    logic [LIM_W-1:0]     v_lim;
    logic [TMO_W-1:0]     v_tmo;
    logic [RC_W-1:0]      v_rc;

    none = '0;
    est_eps = EPS_RST;
    est_limit = LIM_RST;
    est_timeout = TMO_RST;
    est_rc = RC_RST;
    est_primed = 1'b0;
    est_ref_pos = '0;
    est_ref_time = '0;
    est_motion_time = '0;
    est_speed = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    plan = '{
      known_row(24'd0, 32'd1000, 1'b0, 24'd0, 1'b0),         // priming after reset
      item_row(24'd10, 32'd1005, 1'b0),                      // below epsilon
      item_row(24'h7FFFFF, 32'd1010, 1'b0),                  // clamped positive
      item_row(24'h800000, 32'd1011, 1'b0),                  // clamped negative
      item_row(24'h800000, 32'd1011, 1'b0),                  // no change
      item_row(24'h800260, 32'd1011, 1'b0),                  // moved, zero elapsed
      item_row(24'h800260, 32'd1400, 1'b0),                  // still past timeout
      known_row(24'h123456, 32'hFFFFFFFF, 1'b1, 24'd0, 1'b0),
      known_row(24'hFFFFFF, 32'd0, 1'b1, 24'd0, 1'b0),
      known_row(24'd100, 32'hFFFFFFF0, 1'b0, 24'd0, 1'b0),
      item_row(24'd5000, 32'h10, 1'b0),                      // time wraps
      item_row(24'd5050, 32'h20, 1'b0),
      item_row(24'd5051, 32'h30, 1'b0),                      // exactly epsilon
      reg_row(CFG_RC, 32'hFFF00000),                         // zero time constant
      item_row(24'd6000, 32'h40, 1'b0),
      reg_row(CFG_TIMEOUT, 32'hFFFF0000),                    // zero timeout
      item_row(24'd6000, 32'h40, 1'b0),
      reg_row(CFG_LIMIT, 32'hFF7FFFFF),
      item_row(24'h800000, 32'h41, 1'b0),
      reg_row(CFG_EPSILON, 32'hFFFFFFFF),
      item_row(24'h8003FE, 32'h50, 1'b0),
      reg_row(FIRST_SPARE_IDX, 32'h00000005),                // ignored index
      item_row(24'h8003FF, 32'h60, 1'b0),
      known_row(24'h000001, 32'h61, 1'b1, 24'd0, 1'b0)
    };

    foreach (plan[i]) begin
      if (plan[i].is_reg)
        write_reg(plan[i].idx, plan[i].data);
      else
        push_item(plan[i].pos, plan[i].now, plan[i].restart, plan[i].typed, plan[i].want);
    end

    gen_now = 32'h60;
    gen_pos = 24'h8003FF;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin v_eps = '0; v_lim = '0; v_tmo = '0; v_rc = '0; end
        1: begin v_eps = '1; v_lim = '1; v_tmo = '1; v_rc = 20'd1000000; end
        2: begin v_eps = 10'd1; v_lim = 23'd4194304; v_tmo = 16'd1; v_rc = 20'd1; end
        3: begin v_eps = EPS_RST; v_lim = LIM_RST; v_tmo = TMO_RST; v_rc = RC_RST; end
        4: begin v_eps = '0; v_lim = '1; v_tmo = '1; v_rc = '1; end
        default: begin
          v_eps = EPS_W'($urandom_range(0, 200));
          v_lim = LIM_W'($urandom_range(0, 4194304));
          v_tmo = TMO_W'($urandom_range(0, 1000));
          v_rc = RC_W'($urandom_range(1, 1000000));
        end
      endcase
      // junk above each register width must be dropped
      write_reg(CFG_EPSILON, ($urandom << EPS_W) | v_eps);
      write_reg(CFG_LIMIT, ($urandom << LIM_W) | v_lim);
      write_reg(CFG_TIMEOUT, ($urandom << TMO_W) | v_tmo);
      write_reg(CFG_RC, ($urandom << RC_W) | v_rc);
      write_reg(FIRST_SPARE_IDX + CFG_IDX_W'($urandom_range(0, 3)), $urandom);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        calm = (ph * PHASE_ITEMS + k) >= (PHASES * PHASE_ITEMS - CALM_ITEMS);
        r = $urandom_range(0, 99);
        restart = 1'b0;
        if (r < 4) begin
          restart = 1'b1;
          gen_pos = POS_W'($urandom);
          gen_now = $urandom;
        end else if (r < 10) begin
          gen_pos = POS_W'($urandom);
          gen_now = $urandom;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 10)      dt = 0;
          else if (r < 50) dt = $urandom_range(1, 20);
          else if (r < 80) dt = $urandom_range(21, 400);
          else if (r < 95) dt = $urandom_range(401, 70000);
          else             dt = $urandom;
          gen_now = gen_now + dt;
          r = $urandom_range(0, 99);
          if (r < 25)      mag = $urandom_range(0, int'(est_eps) + 2);
          else if (r < 65) mag = $urandom_range(0, 30000);
          else if (r < 80) mag = $urandom_range(0, 8388607);
          else             mag = 0;
          if ($urandom_range(0, 1) == 1) mag = -mag;
          gen_pos = gen_pos + POS_W'(mag);
        end
        pos = gen_pos;
        push_item(pos, gen_now, restart, 1'b0, none);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sse_pkg.sv
rtl/sse_div.sv
rtl/sse_dp.sv
rtl/sse_ctrl.sv
rtl/sparse_sample_speed_estimator.sv
tb/sv/testbench.sv
